[hdl/pidc_pkg.sv]
package pidc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DRIVE_W  = 48;
  localparam int unsigned LIMIT_W  = 47;
  localparam int unsigned CLAMP_W  = 2;

  // apb register map, 8 bytes per register
  localparam int unsigned PADDR_W  = 6;
  localparam int unsigned PDATA_W  = 64;

  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_INTEG_EN    = 3'd3;
  localparam logic [2:0] REG_INTEG_HOLD  = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;

  // clamp status codes
  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

  // one quotient bit per cycle: 33-bit difference magnitude plus 16 fraction bits
  localparam int unsigned DIV_STEPS = 49;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_QSAT,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_ISAT,
    ST_CLAMP,
    ST_SUM,
    ST_DONE
  } state_t;

  // magnitude of a signed 32-bit value, fits 32 bits unsigned
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? (32'd0 - 32'(x)) : 32'(x);
    return r;
  endfunction

  // apply sign to a magnitude and saturate to signed q32.16
  function automatic logic signed [DRIVE_W-1:0] sat48(input logic [63:0] m, input logic neg);
    logic signed [DRIVE_W-1:0] r;
    if (neg) begin
      if (m > 64'h0000_8000_0000_0000) begin
        r = 48'sh8000_0000_0000;
      end else begin
        r = $signed(48'd0 - m[47:0]);
      end
    end else begin
      if (m > 64'h0000_7FFF_FFFF_FFFF) begin
        r = 48'sh7FFF_FFFF_FFFF;
      end else begin
        r = $signed(m[47:0]);
      end
    end
    return r;
  endfunction

endpackage

[hdl/pidc_in_if.sv]
interface pidc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [pidc_pkg::SAMPLE_W-1:0] error_in;
  logic signed [pidc_pkg::SAMPLE_W-1:0] step_time;

  modport source (output valid, cmd, error_in, step_time, input ready);
  modport sink (input valid, cmd, error_in, step_time, output ready);
endinterface

[hdl/pidc_out_if.sv]
interface pidc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidc_pkg::DRIVE_W-1:0]  drive;
  logic        [pidc_pkg::CLAMP_W-1:0]  clamp_status;
  logic                                stale;

  modport source (output valid, drive, clamp_status, stale, input ready);
  modport sink (input valid, drive, clamp_status, stale, output ready);
endinterface

[hdl/pid_with_integrator_clamp_unit.sv]
// channel   direction  word
// sample    in         cmd, error_in (q16.16), step_time (q16.16)
// result    out        drive (q32.16), clamp_status, stale
// apb       in/out     gains, integrator enable/hold, integrator limit
//
// a control step uses the radix-2 restoring divider that forms the derivative
// and five passes through the shared 32x32 multiplier, plus the
// check/add/clamp/sum/load steps. the first sample after reset skips the divider;
// command reset and stale steps go from the check straight to the load.
// the next word is accepted the cycle after the result loads; a finished result
// waits in the output register while the next word is accepted, and a second result
// stalls until it drains. rst is synchronous.
module pid_with_integrator_clamp_unit (
  input  logic                           clk,
  input  logic                           rst,
  pidc_in_if.sink                        sample,
  pidc_out_if.source                     result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidc_pkg::PADDR_W-1:0]   paddr,
  input  logic [pidc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pidc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // configuration registers
  logic signed [31:0]                  prop_gain;
  logic signed [31:0]                  integ_gain;
  logic signed [31:0]                  deriv_gain;
  logic                                integ_enable;
  logic                                integ_hold;
  logic [pidc_pkg::LIMIT_W-1:0]        integ_limit;

  // latched word
  logic                                cmd_q;
  logic signed [31:0]                  err_q;
  logic signed [31:0]                  dt_q;

  // controller state
  logic signed [31:0]                  last_error;
  logic signed [pidc_pkg::DRIVE_W-1:0] last_drive;
  logic signed [pidc_pkg::DRIVE_W-1:0] integral;
  logic                                first_sample;
  logic [pidc_pkg::CLAMP_W-1:0]        sat_state;

  // sequencer
  pidc_pkg::state_t                    state;
  pidc_pkg::state_t                    state_next;

  // work registers
  logic [30:0]                         rem;
  logic [48:0]                         num;
  logic [5:0]                          div_cnt;
  logic                                d_neg;
  logic [31:0]                         diff_mag;
  logic [63:0]                         prod;
  logic signed [pidc_pkg::DRIVE_W-1:0] p_term;
  logic signed [pidc_pkg::DRIVE_W-1:0] d_term;
  logic signed [pidc_pkg::DRIVE_W-1:0] i_term;
  logic [15:0]                         r1_hi;
  logic                                r1_neg;
  logic [79:0]                         acc;
  logic                                stale_q;

  // output register
  logic                                out_valid;
  logic signed [pidc_pkg::DRIVE_W-1:0] out_drive;
  logic [pidc_pkg::CLAMP_W-1:0]        out_clamp;
  logic                                out_stale;
  logic                                out_load;

  // combinational helpers
  logic [31:0]                         mul_a;
  logic [31:0]                         mul_b;
  logic [63:0]                         mul_out;
  logic                                dt_nonpos;
  logic signed [32:0]                  d_sub;
  logic [32:0]                         d_mag;
  logic [31:0]                         err_mag;
  logic [31:0]                         ki_mag;
  logic [31:0]                         rem_sh;
  logic                                q_bit;
  logic [47:0]                         prod_m;
  logic signed [48:0]                  sum49;
  logic signed [48:0]                  lim49;
  logic signed [48:0]                  nlim49;
  logic signed [49:0]                  drive_sum;
  logic                                cfg_wr;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      integ_enable <= 1'b0;
      integ_hold   <= 1'b0;
      integ_limit  <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        pidc_pkg::REG_PROP_GAIN:   prop_gain    <= $signed(pwdata[31:0]);
        pidc_pkg::REG_INTEG_GAIN:  integ_gain   <= $signed(pwdata[31:0]);
        pidc_pkg::REG_DERIV_GAIN:  deriv_gain   <= $signed(pwdata[31:0]);
        pidc_pkg::REG_INTEG_EN:    integ_enable <= pwdata[0];
        pidc_pkg::REG_INTEG_HOLD:  integ_hold   <= pwdata[0];
        pidc_pkg::REG_INTEG_LIMIT: integ_limit  <= pwdata[pidc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[5:3])
      pidc_pkg::REG_PROP_GAIN:   prdata = {32'd0, prop_gain};
      pidc_pkg::REG_INTEG_GAIN:  prdata = {32'd0, integ_gain};
      pidc_pkg::REG_DERIV_GAIN:  prdata = {32'd0, deriv_gain};
      pidc_pkg::REG_INTEG_EN:    prdata = {63'd0, integ_enable};
      pidc_pkg::REG_INTEG_HOLD:  prdata = {63'd0, integ_hold};
      pidc_pkg::REG_INTEG_LIMIT: prdata = {17'd0, integ_limit};
      default:                   prdata = '0;
    endcase
  end

  // word capture
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      cmd_q <= sample.cmd;
      err_q <= sample.error_in;
      dt_q  <= sample.step_time;
    end
  end

  // decode helpers
  assign dt_nonpos = dt_q[31] || (dt_q == '0);
  assign d_sub     = {err_q[31], err_q} - {last_error[31], last_error};
  assign d_mag     = d_sub[32] ? (33'd0 - 33'(d_sub)) : 33'(d_sub);
  assign err_mag   = pidc_pkg::mag32(err_q);
  assign ki_mag    = pidc_pkg::mag32(integ_gain);

  // divider step
  assign rem_sh = {rem, num[48]};
  assign q_bit  = (rem_sh >= 32'(dt_q));

  // shared multiplier
  assign mul_out = mul_a * mul_b;
  assign prod_m  = prod[63:16];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample.ready = (state == pidc_pkg::ST_IDLE);

  // next state and multiplier operands
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      pidc_pkg::ST_IDLE: begin
        if (sample.valid) state_next = pidc_pkg::ST_CHECK;
      end
      pidc_pkg::ST_CHECK: begin
        if (cmd_q || dt_nonpos) begin
          state_next = pidc_pkg::ST_DONE;
        end else if (first_sample) begin
          state_next = pidc_pkg::ST_M0;
        end else begin
          state_next = pidc_pkg::ST_DIV;
        end
      end
      pidc_pkg::ST_DIV: begin
        if (div_cnt == 6'(pidc_pkg::DIV_STEPS - 1)) state_next = pidc_pkg::ST_QSAT;
      end
      pidc_pkg::ST_QSAT: state_next = pidc_pkg::ST_M0;
      pidc_pkg::ST_M0: begin
        mul_a      = err_mag;
        mul_b      = pidc_pkg::mag32(prop_gain);
        state_next = pidc_pkg::ST_M1;
      end
      pidc_pkg::ST_M1: begin
        mul_a      = diff_mag;
        mul_b      = pidc_pkg::mag32(deriv_gain);
        state_next = pidc_pkg::ST_M2;
      end
      pidc_pkg::ST_M2: begin
        mul_a      = err_mag;
        mul_b      = 32'(dt_q);
        state_next = pidc_pkg::ST_M3;
      end
      pidc_pkg::ST_M3: begin
        mul_a      = prod[47:16];
        mul_b      = ki_mag;
        state_next = pidc_pkg::ST_M4;
      end
      pidc_pkg::ST_M4: begin
        mul_a      = {16'd0, r1_hi};
        mul_b      = ki_mag;
        state_next = pidc_pkg::ST_M5;
      end
      pidc_pkg::ST_M5:    state_next = pidc_pkg::ST_ISAT;
      pidc_pkg::ST_ISAT:  state_next = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: state_next = pidc_pkg::ST_SUM;
      pidc_pkg::ST_SUM:   state_next = pidc_pkg::ST_DONE;
      pidc_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = pidc_pkg::ST_IDLE;
        end
      end
      default: state_next = pidc_pkg::ST_IDLE;
    endcase
  end

  // datapath work registers
  always_ff @(posedge clk) begin
    prod <= mul_out;
    case (state)
      pidc_pkg::ST_CHECK: begin
        num      <= {d_mag, 16'd0};
        rem      <= '0;
        div_cnt  <= '0;
        d_neg    <= d_sub[32];
        diff_mag <= '0;
        stale_q  <= !cmd_q && dt_nonpos;
      end
      pidc_pkg::ST_DIV: begin
        rem     <= q_bit ? 31'(rem_sh - 32'(dt_q)) : rem_sh[30:0];
        num     <= {num[47:0], q_bit};
        div_cnt <= div_cnt + 6'd1;
      end
      pidc_pkg::ST_QSAT: begin
        // quotient saturates to the q16.16 range
        if (num > 49'h0_0000_7FFF_FFFF) begin
          diff_mag <= d_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          diff_mag <= num[31:0];
        end
      end
      pidc_pkg::ST_M1: begin
        p_term <= pidc_pkg::sat48({16'd0, prod_m},
                                  (err_q[31] != prop_gain[31]) && (prod_m != '0));
      end
      pidc_pkg::ST_M2: begin
        d_term <= pidc_pkg::sat48({16'd0, prod_m},
                                  (d_neg != deriv_gain[31]) && (prod_m != '0));
      end
      pidc_pkg::ST_M3: begin
        // e*dt stays below 2^62, keep its upper bits for the second pass
        r1_hi  <= prod[63:48];
        r1_neg <= err_q[31] && (prod_m != '0);
      end
      pidc_pkg::ST_M4: acc <= {16'd0, prod};
      pidc_pkg::ST_M5: acc <= acc + {prod[47:0], 32'd0};
      pidc_pkg::ST_ISAT: begin
        i_term <= pidc_pkg::sat48(acc[79:16],
                                  (r1_neg != integ_gain[31]) && (acc[79:16] != '0));
      end
      default: ;
    endcase
  end

  // integrator clamp and drive sum
  assign sum49     = {integral[47], integral} + {i_term[47], i_term};
  assign lim49     = $signed({2'b00, integ_limit});
  assign nlim49    = 49'sd0 - lim49;
  assign drive_sum = {{2{p_term[47]}}, p_term} + {{2{integral[47]}}, integral}
                   + {{2{d_term[47]}}, d_term};

  // controller state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      last_drive   <= '0;
      integral     <= '0;
      first_sample <= 1'b1;
      sat_state    <= pidc_pkg::CLAMP_NONE;
    end else begin
      case (state)
        pidc_pkg::ST_CHECK: begin
          if (cmd_q) begin
            last_error   <= '0;
            last_drive   <= '0;
            integral     <= '0;
            first_sample <= 1'b1;
            sat_state    <= pidc_pkg::CLAMP_NONE;
          end else if (!dt_nonpos) begin
            first_sample <= 1'b0;
          end
        end
        pidc_pkg::ST_CLAMP: begin
          last_error <= err_q;
          if (!integ_enable) begin
            integral <= '0;
          end else if (!integ_hold) begin
            if (sum49 > lim49) begin
              integral  <= lim49[47:0];
              sat_state <= pidc_pkg::CLAMP_HIGH;
            end else if (sum49 < nlim49) begin
              integral  <= nlim49[47:0];
              sat_state <= pidc_pkg::CLAMP_LOW;
            end else begin
              integral  <= sum49[47:0];
              sat_state <= pidc_pkg::CLAMP_NONE;
            end
          end
        end
        pidc_pkg::ST_SUM: begin
          if (drive_sum[49:47] == 3'b000 || drive_sum[49:47] == 3'b111) begin
            last_drive <= drive_sum[47:0];
          end else begin
            last_drive <= drive_sum[49] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive <= last_drive;
      out_clamp <= sat_state;
      out_stale <= stale_q;
    end
  end

  assign result.valid        = out_valid;
  assign result.drive        = out_drive;
  assign result.clamp_status = out_clamp;
  assign result.stale        = out_stale;

`ifndef SYNTH
  // a word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("input accepted while previous word still in progress");

  // an active integrator update lands inside the clamp bounds
  a_integral_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == pidc_pkg::ST_CLAMP && integ_enable && !integ_hold) |=>
      (integral <= $signed({1'b0, integ_limit}) &&
       integral >= 48'sd0 - $signed({1'b0, integ_limit})))
    else $error("integral outside clamp bounds after update");

  // command reset returns the controller state to its reset values
  a_cmd_reset: assert property (@(posedge clk) disable iff (rst)
    (state == pidc_pkg::ST_CHECK && cmd_q) |=>
      (first_sample && integral == '0 && last_drive == '0 &&
       sat_state == pidc_pkg::CLAMP_NONE))
    else $error("command reset did not clear controller state");
`endif

endmodule
